/* sv/rwct_pkg.sv */
// Package: shared types, constants and helpers for the wall column texturer.
package rwct_pkg;

	localparam int TEXTURE_COUNT_DEF     = 4;
	localparam int TEXTURE_SIZE_LOG2_DEF = 6;

	localparam int DIV_W = 27;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_EMIT  = 2'd2;

	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd0;
	localparam logic [1:0] REG_TEXTURE_WIDTH = 2'd1;
	localparam logic [1:0] REG_TEX_HEIGHT_L2 = 2'd2;

	localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd480;
	localparam logic [6:0]  TEXTURE_WIDTH_RST = 7'd64;
	localparam logic [2:0]  TEX_HEIGHT_L2_RST = 3'd6;

	localparam logic [23:0] SHADE_MASK = 24'h7F7F7F;

	typedef struct packed {
		logic [1:0]         op;
		logic [13:0]        texel_address;
		logic [23:0]        texel_color;
		logic [9:0]         column;
		logic               hit_side;
		logic               step_x_positive;
		logic               step_y_positive;
		logic signed [15:0] ray_dir_x;
		logic signed [15:0] ray_dir_y;
		logic [23:0]        player_x;
		logic [23:0]        player_y;
		logic [23:0]        perp_distance;
	} in_item_t;

	typedef struct packed {
		logic [9:0]  pixel_column;
		logic [10:0] pixel_row;
		logic [23:0] pixel_color;
		logic        last_pixel;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic start;
		logic emit;
		logic div2_start;
		logic step_load;
		logic commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic div_done;
		logic out_free;
	} stat_t;

	function automatic logic [7:0] mod_small(input logic [7:0] x, input logic [3:0] m);
		logic [11:0] r;
		logic [11:0] d;
		r = {4'd0, x};
		for (int i = 7; i >= 0; i--) begin
			d = 12'(m) << i;
			if (r >= d) r = r - d;
		end
		return r[7:0];
	endfunction

endpackage

/* sv/rwct_ram.sv */
// Generic single-port-write, registered-read RAM.
module rwct_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/rwct_div.sv */
// Restoring divider, one quotient bit per cycle.
module rwct_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rwct_pkg::DIV_W-1:0] dividend,
	input  logic [rwct_pkg::DIV_W-1:0] divisor,
	output logic [rwct_pkg::DIV_W-1:0] quotient,
	output logic                      done
);

	localparam int W   = rwct_pkg::DIV_W;
	localparam int CW  = $clog2(W);

	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;
	logic          ge;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = ~diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff : shifted;
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

/* sv/rwct_ctrl.sv */
// Controller state machine for the wall column texturer.
module rwct_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  rwct_pkg::stat_t     stat,
	output rwct_pkg::cmd_t      cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DIV1   = 6'b000010,
		ST_DIV2   = 6'b000100,
		ST_MUL    = 6'b001000,
		ST_COMMIT = 6'b010000,
		ST_READ   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   acc;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid & in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					cmd.load  = (op == rwct_pkg::OP_LOAD);
					cmd.start = (op == rwct_pkg::OP_START);
					cmd.emit  = (op == rwct_pkg::OP_EMIT) & stat.active;
					if (op == rwct_pkg::OP_START) state_d = ST_DIV1;
					else if (op == rwct_pkg::OP_EMIT && stat.active) state_d = ST_READ;
				end
			end
			ST_DIV1: begin
				if (stat.div_done) begin
					cmd.div2_start = 1'b1;
					state_d        = ST_DIV2;
				end
			end
			ST_DIV2: begin
				if (stat.div_done) begin
					cmd.step_load = 1'b1;
					state_d       = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_COMMIT;
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_READ: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

/* sv/rwct_dp.sv */
// Datapath: configuration, column setup arithmetic, texel store and pixel output.
module rwct_dp #(
	parameter int TEXTURE_COUNT     = rwct_pkg::TEXTURE_COUNT_DEF,
	parameter int TEXTURE_SIZE_LOG2 = rwct_pkg::TEXTURE_SIZE_LOG2_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [10:0]          cfg_data,
	input  rwct_pkg::in_item_t   in_data,
	input  rwct_pkg::cmd_t       cmd,
	output rwct_pkg::stat_t      stat,
	input  logic                 out_ready,
	output logic                 out_valid,
	output rwct_pkg::out_item_t  out_data
);

	localparam int TSL     = TEXTURE_SIZE_LOG2;
	localparam int TB      = 2 * TSL;
	localparam int DEPTH   = TEXTURE_COUNT << TB;
	localparam int AW      = $clog2(DEPTH);
	localparam int W       = rwct_pkg::DIV_W;
	localparam int TEX_MAX = 1 << TSL;

	logic [10:0] sh_q;
	logic [6:0]  tw_reg_q;
	logic [2:0]  thl_q;
	logic [2:0]  hl_c;

	logic [9:0]  cur_col_q;
	logic [10:0] cur_row_q;
	logic [10:0] last_row_q;
	logic [31:0] tpos_q;
	logic [31:0] tstep_q;
	logic [TSL-1:0] tcol_q;
	logic [1:0]  tsel_q;
	logic        shade_q;
	logic        active_q;

	logic signed [29:0] prod_q;
	logic [15:0] wpos_q;
	logic        mirror_q;
	logic [1:0]  sel_pend_q;
	logic [9:0]  col_pend_q;
	logic        side_pend_q;
	logic [10:0] h_q;
	logic [TSL:0] tw_q;
	logic [2:0]  hl_q;
	logic [15:0] frac_s1;
	logic [TSL+16:0] txp_s2;
	logic [W-1:0] line_q;
	logic [W-1:0] step_q;
	logic [32:0] mult_q;

	logic [23:0] dist_c;
	logic signed [15:0] dir_c;
	logic [TSL:0] tw_c;
	logic [10:0] h_c;

	logic         div_start;
	logic [W-1:0] div_dividend;
	logic [W-1:0] div_divisor;
	logic [W-1:0] quotient;
	logic         div_done;
	logic [W-1:0] line_c;

	logic [W-1:0] h27;
	logic         ge;
	logic [W-1:0] dhl;
	logic         neg;
	logic [W-1:0] mag;
	logic [31:0]  half;
	logic [W:0]   hsum;
	logic [W-1:0] hs;
	logic [10:0]  end_c;
	logic [10:0]  start_c;
	logic [TSL:0] tx;
	logic [TSL:0] tx_m;

	logic        pneg;
	logic [31:0] pmag;
	logic [15:0] whole;
	logic [TSL-1:0] hmask;
	logic [TSL-1:0] trow;
	logic [7:0]  sel_m;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [23:0] rdata;

	logic [9:0]  em_col_s1;
	logic [10:0] em_row_s1;
	logic        em_last_s1;
	logic        em_shade_s1;
	logic        out_valid_q;
	rwct_pkg::out_item_t out_q;
	logic        last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q     <= rwct_pkg::SCREEN_HEIGHT_RST;
			tw_reg_q <= rwct_pkg::TEXTURE_WIDTH_RST;
			thl_q    <= rwct_pkg::TEX_HEIGHT_L2_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rwct_pkg::REG_SCREEN_HEIGHT: sh_q     <= cfg_data;
				rwct_pkg::REG_TEXTURE_WIDTH: tw_reg_q <= cfg_data[6:0];
				rwct_pkg::REG_TEX_HEIGHT_L2: thl_q    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign hl_c  = (int'(thl_q) > TSL) ? 3'(TSL) : thl_q;
	assign dist_c = (in_data.perp_distance == '0) ? 24'd1 : in_data.perp_distance;
	assign dir_c  = in_data.hit_side ? in_data.ray_dir_x : in_data.ray_dir_y;
	assign h_c    = (sh_q < 11'd2) ? 11'd2 : sh_q;
	assign tw_c   = (tw_reg_q == '0) ? (TSL+1)'(1) :
		((int'(tw_reg_q) > TEX_MAX) ? (TSL+1)'(TEX_MAX) : (TSL+1)'(tw_reg_q));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			prod_q      <= 30'($signed({1'b0, dist_c}) * dir_c);
			wpos_q      <= in_data.hit_side ? in_data.player_x[15:0] : in_data.player_y[15:0];
			mirror_q    <= (!in_data.hit_side && in_data.ray_dir_x > 16'sd0) ||
				(in_data.hit_side && in_data.ray_dir_y < 16'sd0);
			sel_pend_q  <= in_data.hit_side ? {1'b0, in_data.step_y_positive} :
				{1'b1, in_data.step_x_positive};
			col_pend_q  <= in_data.column;
			side_pend_q <= in_data.hit_side;
			h_q         <= h_c;
			tw_q        <= tw_c;
			hl_q        <= hl_c;
		end
		frac_s1 <= prod_q[29:14] + wpos_q;
		txp_s2  <= (TSL+17)'(frac_s1 * tw_q);
		if (cmd.div2_start) line_q <= line_c;
		if (cmd.step_load) step_q <= quotient;
		mult_q <= 33'(mag * step_q);
	end

	assign line_c       = (quotient == '0) ? W'(1) : quotient;
	assign div_start    = cmd.start | cmd.div2_start;
	assign div_dividend = cmd.start ? {h_c, 16'd0} : (W'(1) << (5'(hl_q) + 5'd16));
	assign div_divisor  = cmd.start ? W'(dist_c) : line_c;

	rwct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.done     (div_done)
	);

	assign h27     = W'(h_q);
	assign ge      = (h27 >= line_q);
	assign dhl     = h27 - line_q;
	assign neg     = ge & dhl[0];
	assign mag     = ge ? W'(neg) : (line_q - h27);
	assign half    = mult_q[32:1];
	assign hsum    = {1'b0, h27} + {1'b0, line_q};
	assign hs      = hsum[W:1];
	assign end_c   = (hs >= h27) ? (h_q - 11'd1) : hs[10:0];
	assign start_c = ge ? dhl[11:1] : 11'd0;
	assign tx      = txp_s2[TSL+16:16];
	assign tx_m    = mirror_q ? (tw_q - tx - (TSL+1)'(1)) : tx;

	assign pneg  = tpos_q[31];
	assign pmag  = pneg ? (32'd0 - tpos_q) : tpos_q;
	assign whole = pneg ? (16'd0 - pmag[31:16]) : pmag[31:16];
	assign hmask = TSL'((9'd1 << hl_c) - 9'd1);
	assign trow  = whole[TSL-1:0] & hmask;
	assign sel_m = rwct_pkg::mod_small({6'd0, tsel_q}, 4'(TEXTURE_COUNT));
	assign raddr = (AW'(sel_m) << TB) | AW'({trow, tcol_q});
	assign last_c = (cur_row_q == last_row_q);

	generate
		if (TB >= 14) begin : g_wfull
			assign waddr = AW'(in_data.texel_address);
		end else begin : g_wwrap
			assign waddr = (AW'(rwct_pkg::mod_small(8'(in_data.texel_address[13:TB]),
				4'(TEXTURE_COUNT))) << TB) | AW'(in_data.texel_address[TB-1:0]);
		end
	endgenerate

	rwct_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (waddr),
		.wdata (in_data.texel_color),
		.re    (cmd.emit),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			last_row_q <= '0;
			tpos_q     <= '0;
			tstep_q    <= '0;
			tcol_q     <= '0;
			tsel_q     <= '0;
			shade_q    <= 1'b0;
			active_q   <= 1'b0;
		end else if (cmd.commit) begin
			cur_col_q  <= col_pend_q;
			cur_row_q  <= start_c;
			last_row_q <= end_c;
			tpos_q     <= neg ? (32'd0 - half) : half;
			tstep_q    <= 32'(step_q);
			tcol_q     <= tx_m[TSL-1:0];
			tsel_q     <= sel_pend_q;
			shade_q    <= side_pend_q;
			active_q   <= 1'b1;
		end else if (cmd.emit) begin
			tpos_q    <= tpos_q + tstep_q;
			cur_row_q <= cur_row_q + 11'd1;
			if (last_c) active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			em_col_s1   <= cur_col_q;
			em_row_s1   <= cur_row_q;
			em_last_s1  <= last_c;
			em_shade_s1 <= shade_q;
		end
		if (cmd.out_load) begin
			out_q.pixel_column <= em_col_s1;
			out_q.pixel_row    <= em_row_s1;
			out_q.pixel_color  <= em_shade_s1 ? ((rdata >> 1) & rwct_pkg::SHADE_MASK) : rdata;
			out_q.last_pixel   <= em_last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign stat.active   = active_q;
	assign stat.div_done = div_done;
	assign stat.out_free = ~out_valid_q | out_ready;

endmodule

/* sv/raycast_wall_column_texturer.sv */
// Top level of the raycaster wall column texturer.
//
//  channel  signals                        direction  carries
//  in       in_valid in_ready in_data      input      op, texel, column setup fields
//  out      out_valid out_ready out_data   output     pixel column, row, color, last flag
//  cfg      cfg_valid cfg_ready cfg_index  input      register index and cfg_data
//
// Texel load writes the RAM on accept; pixel emit goes through the RAM read register.
// Column start runs two passes of the shared restoring divider, then ST_MUL and ST_COMMIT.
// Reset clears control state and sets registers to 480, 64, 6; the texel store is not cleared.
// A finished pixel waits in the output register; loads go on, the next emit stalls.
module raycast_wall_column_texturer #(
	parameter int TEXTURE_COUNT     = rwct_pkg::TEXTURE_COUNT_DEF,
	parameter int TEXTURE_SIZE_LOG2 = rwct_pkg::TEXTURE_SIZE_LOG2_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rwct_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rwct_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [10:0]         cfg_data
);

	rwct_pkg::cmd_t  cmd;
	rwct_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	rwct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (in_data.op),
		.stat     (stat),
		.cmd      (cmd)
	);

	rwct_dp #(
		.TEXTURE_COUNT     (TEXTURE_COUNT),
		.TEXTURE_SIZE_LOG2 (TEXTURE_SIZE_LOG2)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
